### rtl/core/led_effect_sequencer_core_defines.svh
// Assertion macros shared by the LED effect sequencer RTL.
`ifndef LED_EFFECT_SEQUENCER_CORE_DEFINES_SVH
`define LED_EFFECT_SEQUENCER_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside of reset.
`define LES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside of reset.
`define LES_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### rtl/core/les_pkg.sv
// Types, constants and tables shared by the LED effect sequencer.
`timescale 1ns / 1ps
`default_nettype none

package les_pkg;

  // Transaction kinds on the input channel
  typedef enum logic {
    OpCommand = 1'b0,
    OpTick    = 1'b1
  } les_op_e;

  // Frame kinds on the output channel
  typedef enum logic {
    KindPattern = 1'b0,
    KindRgb     = 1'b1
  } les_kind_e;

  // Mode codes
  localparam logic [7:0] ModeStaticLoLast  = 8'd10;
  localparam logic [7:0] ModeCycle         = 8'd11;
  localparam logic [7:0] ModeBlink         = 8'd12;
  localparam logic [7:0] ModeFade          = 8'd13;
  localparam logic [7:0] ModeChase         = 8'd14;
  localparam logic [7:0] ModeBrighter      = 8'd15;
  localparam logic [7:0] ModeDimmer        = 8'd16;
  localparam logic [7:0] ModeStaticHiFirst = 8'd17;
  localparam logic [7:0] ModeStaticHiLast  = 8'd31;

  // Brightness
  localparam logic [2:0] LevelMin   = 3'd1;
  localparam logic [2:0] LevelMax   = 3'd5;
  localparam logic [2:0] LevelReset = 3'd2;
  localparam logic [2:0] BlinkLevel = 3'd5;

  // Pattern codes
  localparam logic [4:0] PatOff     = 5'd0;
  localparam logic [4:0] PatRed     = 5'd4;
  localparam logic [4:0] ChaseBase  = 5'd17;

  // Colour cycle
  localparam logic [2:0] CycleLast  = 3'd6;
  localparam logic [2:0] CycleBad   = 3'd7;

  // Blink segments and counters
  localparam logic [1:0] BlinkSeg0     = 2'd0;
  localparam logic [1:0] BlinkSeg1     = 2'd1;
  localparam logic [1:0] BlinkSeg2     = 2'd2;
  localparam logic [1:0] BlinkSegBad   = 2'd3;
  localparam logic [4:0] BlinkOnLast0  = 5'd6;
  localparam logic [4:0] BlinkIdle0    = 5'd9;
  localparam logic [4:0] BlinkIdle2    = 5'd13;
  localparam logic [4:0] BlinkOnLast1  = 5'd12;
  localparam logic [4:0] BlinkIdle1    = 5'd15;
  localparam logic [4:0] BlinkCountRst = 5'd1;
  localparam logic [2:0] BlinkFlagRst  = 3'd1;
  localparam logic [2:0] BlinkFlagOff  = 3'd0;
  localparam logic [2:0] BlinkFlagOnHi = 3'd3;
  localparam logic [2:0] BlinkFlagLast = 3'd4;

  // Fade segments
  localparam logic [2:0] FadeGreenUp  = 3'd0;
  localparam logic [2:0] FadeRedDown  = 3'd1;
  localparam logic [2:0] FadeBlueUp   = 3'd2;
  localparam logic [2:0] FadeGreenDn  = 3'd3;
  localparam logic [2:0] FadeRedUp    = 3'd4;
  localparam logic [2:0] FadeBlueDown = 3'd5;
  localparam logic [7:0] FadeStep     = 8'd10;
  localparam logic [7:0] FadeMax      = 8'd255;

  // Chase
  localparam logic [3:0] ChaseLast    = 4'd14;
  localparam logic [3:0] ChaseLoop    = 4'd6;

  // Sequencer state
  typedef struct packed {
    logic [7:0] cur_mode;
    logic [7:0] prev_mode;
    logic [2:0] level;
    logic [2:0] cycle_pos;
    logic [1:0] blink_phase;
    logic [4:0] blink_count;
    logic [2:0] blink_flag;
    logic [2:0] fade_phase;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [3:0] chase_pos;
  } les_state_t;

  localparam les_state_t StateReset = '{
    cur_mode:    8'd0,
    prev_mode:   8'd0,
    level:       LevelReset,
    cycle_pos:   3'd0,
    blink_phase: BlinkSeg0,
    blink_count: BlinkCountRst,
    blink_flag:  BlinkFlagRst,
    fade_phase:  FadeGreenUp,
    red:         FadeMax,
    green:       8'd0,
    blue:        8'd0,
    chase_pos:   4'd0
  };

  // One frame request
  typedef struct packed {
    logic       kind;
    logic [4:0] pattern;
    logic [2:0] brightness;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } les_frame_t;

  // Colour cycle table
  function automatic logic [4:0] cycle_code(input logic [2:0] pos);
    logic [4:0] code;
    case (pos)
      3'd0:    code = 5'd4;
      3'd1:    code = 5'd2;
      3'd2:    code = 5'd7;
      3'd3:    code = 5'd3;
      3'd4:    code = 5'd8;
      3'd5:    code = 5'd10;
      3'd6:    code = 5'd9;
      default: code = 5'd4;
    endcase
    return code;
  endfunction

  // Modes that answer a command with a fixed pattern
  function automatic logic is_static(input logic [7:0] mode);
    return (mode <= ModeStaticLoLast) ||
           ((mode >= ModeStaticHiFirst) && (mode <= ModeStaticHiLast));
  endfunction

endpackage

`default_nettype wire

### rtl/core/led_effect_sequencer_core.sv
// Top level of the LED effect sequencer: input register, step logic, frame register.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-------------------------------------------------
//  in      | in_valid_i/in_ready_o | operation_i, mode_code_i
//  out     | out_valid_o/out_ready_i | output_kind_o, pattern_code_o, brightness_o,
//          |                      | red_o, green_o, blue_o
//
// A transaction is registered in the input register, then processed by the step
// logic; a frame, if any, is registered in the frame register for the output. One
// transaction per cycle is sustained while the frame register drains; a held frame
// stalls the input register, which then drops in_ready_o. Reset clears the handshake
// and the effect state to level 2, mode 0, and a red fade colour.
`timescale 1ns / 1ps
`default_nettype none
`include "led_effect_sequencer_core_defines.svh"

module led_effect_sequencer_core
  import les_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       operation_i,
  input  logic [7:0] mode_code_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       output_kind_o,
  output logic [4:0] pattern_code_o,
  output logic [2:0] brightness_o,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o
);

  logic       in_valid_q, in_valid_d;
  logic       op_q;
  logic [7:0] mode_q;
  logic       in_adv;
  les_state_t state_q, state_d;
  les_state_t step_state;
  logic       step_emit;
  les_frame_t step_frame;
  logic       out_valid_q, out_valid_d;
  les_frame_t frame_q;

  // Input register advances when the frame register is free or draining
  assign in_adv     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || in_adv;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_ready_o) in_valid_d = in_valid_i;
  end

  // Step logic
  les_step u_step (
    .state_i (state_q),
    .op_i    (op_q),
    .mode_i  (mode_q),
    .state_o (step_state),
    .emit_o  (step_emit),
    .frame_o (step_frame)
  );

  assign state_d = in_adv ? step_state : state_q;

  // Frame register
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_adv && step_emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= StateReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q   <= operation_i;
      mode_q <= mode_code_i;
    end
    if (in_adv && step_emit) begin
      frame_q <= step_frame;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign output_kind_o  = frame_q.kind;
  assign pattern_code_o = frame_q.pattern;
  assign brightness_o   = frame_q.brightness;
  assign red_o          = frame_q.red;
  assign green_o        = frame_q.green;
  assign blue_o         = frame_q.blue;

  // Checks
  `LES_ASSERT(a_level_range,
    (state_q.level >= LevelMin) && (state_q.level <= LevelMax),
    "brightness level out of range")
  `LES_ASSERT(a_in_hold,
    (in_valid_q && !in_adv) |=> (in_valid_q && $stable(mode_q) && $stable(op_q)),
    "input register lost a stalled transaction")
  `LES_ASSERT(a_rgb_no_pattern,
    (out_valid_q && frame_q.kind) |-> (frame_q.pattern == PatOff),
    "RGB frame carries a pattern code")
  `LES_ASSERT_NEVER(a_seq_state,
    (state_q.chase_pos == 4'd15) || (state_q.blink_phase == BlinkSegBad) ||
    (state_q.fade_phase > FadeBlueDown),
    "sequence state reached an unused code")

endmodule

`default_nettype wire

### rtl/core/les_step.sv
// Next-state and frame logic for one command or tick transaction.
`timescale 1ns / 1ps
`default_nettype none

module les_step
  import les_pkg::*;
(
  input  les_state_t state_i,
  input  logic       op_i,
  input  logic [7:0] mode_i,
  output les_state_t state_o,
  output logic       emit_o,
  output les_frame_t frame_o
);

  les_state_t s;
  les_frame_t f;
  logic       emit;
  logic [7:0] m;
  logic [2:0] cyc_p;
  logic [4:0] idle_end;
  logic [7:0] fade_val;
  logic [7:0] fade_new;
  logic [8:0] fade_sum;
  logic       fade_up;
  logic       fade_sat;
  logic [2:0] fade_next;

  always_comb begin
    s         = state_i;
    f         = '0;
    emit      = 1'b0;
    m         = mode_i;
    cyc_p     = 3'd0;
    idle_end  = BlinkIdle0;
    fade_val  = 8'd0;
    fade_new  = 8'd0;
    fade_sum  = 9'd0;
    fade_up   = 1'b0;
    fade_sat  = 1'b0;
    fade_next = FadeGreenUp;

    if (op_i == OpCommand) begin
      // Mode command: restart sequences or step brightness
      case (mode_i)
        ModeCycle: s.cycle_pos = 3'd0;
        ModeBlink: begin
          s.blink_phase = BlinkSeg0;
          s.blink_count = BlinkCountRst;
          s.blink_flag  = BlinkFlagRst;
        end
        ModeFade:  s.fade_phase = FadeGreenUp;
        ModeChase: s.chase_pos = 4'd0;
        ModeBrighter: begin
          if (s.level < LevelMax) s.level = s.level + 3'd1;
          if (s.level < LevelMin) s.level = LevelMin;
          m = state_i.prev_mode;
        end
        ModeDimmer: begin
          if (s.level > LevelMin) s.level = s.level - 3'd1;
          if (s.level > LevelMax) s.level = LevelMax;
          if (s.level < LevelMin) s.level = LevelMin;
          m = state_i.prev_mode;
        end
        default: ;
      endcase
      s.cur_mode  = m;
      s.prev_mode = m;
      if (is_static(m)) begin
        emit         = 1'b1;
        f.kind       = KindPattern;
        f.pattern    = m[4:0];
        f.brightness = s.level;
      end
    end else begin
      // Timer tick: animate the current mode
      case (state_i.cur_mode)
        ModeCycle: begin
          cyc_p        = (state_i.cycle_pos == CycleBad) ? 3'd0 : state_i.cycle_pos;
          emit         = 1'b1;
          f.pattern    = cycle_code(cyc_p);
          f.brightness = state_i.level;
          s.cycle_pos  = (cyc_p >= CycleLast) ? 3'd0 : cyc_p + 3'd1;
        end

        ModeBlink: begin
          case (state_i.blink_phase)
            BlinkSeg0, BlinkSeg2: begin
              idle_end = (state_i.blink_phase == BlinkSeg0) ? BlinkIdle0 : BlinkIdle2;
              if (state_i.blink_count <= BlinkOnLast0) begin
                emit         = 1'b1;
                f.pattern    = (state_i.blink_flag == BlinkFlagRst) ? PatRed : PatOff;
                f.brightness = BlinkLevel;
                s.blink_flag = (state_i.blink_flag == BlinkFlagRst) ? BlinkFlagOff
                                                                    : state_i.blink_flag + 3'd1;
                s.blink_count = state_i.blink_count + 5'd1;
              end else if (state_i.blink_count <= idle_end) begin
                s.blink_count = state_i.blink_count + 5'd1;
              end else begin
                s.blink_count = BlinkCountRst;
                s.blink_phase = (state_i.blink_phase == BlinkSeg0) ? BlinkSeg1 : BlinkSeg0;
                s.blink_flag  = BlinkFlagRst;
              end
            end
            BlinkSeg1: begin
              if (state_i.blink_count <= BlinkOnLast1) begin
                emit         = 1'b1;
                f.pattern    = (state_i.blink_flag <= BlinkFlagOnHi) ? PatRed : PatOff;
                f.brightness = BlinkLevel;
                s.blink_flag = (state_i.blink_flag == BlinkFlagLast) ? BlinkFlagRst
                                                                     : state_i.blink_flag + 3'd1;
                s.blink_count = state_i.blink_count + 5'd1;
              end else if (state_i.blink_count <= BlinkIdle1) begin
                s.blink_count = state_i.blink_count + 5'd1;
              end else begin
                s.blink_count = BlinkCountRst;
                s.blink_phase = BlinkSeg2;
                s.blink_flag  = BlinkFlagRst;
              end
            end
            default: ;
          endcase
        end

        ModeFade: begin
          emit         = 1'b1;
          f.kind       = KindRgb;
          f.brightness = state_i.level;
          f.red        = state_i.red;
          f.green      = state_i.green;
          f.blue       = state_i.blue;
          // pick the channel and direction of this segment
          case (state_i.fade_phase)
            FadeGreenUp:  begin fade_val = state_i.green; fade_up = 1'b1; fade_next = FadeRedDown;  end
            FadeRedDown:  begin fade_val = state_i.red;   fade_up = 1'b0; fade_next = FadeBlueUp;   end
            FadeBlueUp:   begin fade_val = state_i.blue;  fade_up = 1'b1; fade_next = FadeGreenDn;  end
            FadeGreenDn:  begin fade_val = state_i.green; fade_up = 1'b0; fade_next = FadeRedUp;    end
            FadeRedUp:    begin fade_val = state_i.red;   fade_up = 1'b1; fade_next = FadeBlueDown; end
            FadeBlueDown: begin fade_val = state_i.blue;  fade_up = 1'b0; fade_next = FadeGreenUp;  end
            default: ;
          endcase
          // saturating step
          fade_sum = {1'b0, fade_val} + {1'b0, FadeStep};
          if (fade_up) begin
            fade_sat = fade_sum > {1'b0, FadeMax};
            fade_new = fade_sat ? FadeMax : fade_sum[7:0];
          end else begin
            fade_sat = fade_val < FadeStep;
            fade_new = fade_sat ? 8'd0 : fade_val - FadeStep;
          end
          case (state_i.fade_phase)
            FadeGreenUp, FadeGreenDn:  s.green = fade_new;
            FadeRedDown, FadeRedUp:    s.red   = fade_new;
            FadeBlueUp, FadeBlueDown:  s.blue  = fade_new;
            default: ;
          endcase
          if (fade_sat && (state_i.fade_phase <= FadeBlueDown)) s.fade_phase = fade_next;
        end

        ModeChase: begin
          // head and loop codes both run as base plus position
          if (state_i.chase_pos <= ChaseLast) begin
            emit         = 1'b1;
            f.pattern    = ChaseBase + {1'b0, state_i.chase_pos};
            f.brightness = state_i.level;
          end
          s.chase_pos = (state_i.chase_pos == ChaseLast) ? ChaseLoop : state_i.chase_pos + 4'd1;
        end

        default: ;
      endcase
    end
  end

  assign state_o = s;
  assign emit_o  = emit;
  assign frame_o = f;

endmodule

`default_nettype wire

### tb/led_effect_sequencer_core_test.sv
// Self-checking testbench for the LED effect sequencer core: predicted frames vs. DUT frames.
`timescale 1ns / 1ps

module led_effect_sequencer_core_test;
  import les_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  // Tracks the effect state, predicts the frame of each accepted transaction
  // and compares delivered frames against the oldest prediction.
  class effect_tracker;
    logic [7:0] mode;
    logic [7:0] last_mode;
    logic [2:0] level;
    logic [2:0] cyc_pos;
    logic [1:0] blink_seg;
    logic [4:0] blink_cnt;
    logic [2:0] blink_flag;
    logic [2:0] fade_seg;
    logic [7:0] rgb [3];
    logic [3:0] chase_pos;
    logic [4:0] cycle_codes [7] = '{5'd4, 5'd2, 5'd7, 5'd3, 5'd8, 5'd10, 5'd9};
    les_frame_t due_frames [$];
    int unsigned mismatches;
    int unsigned frames_seen;

    function new();
      mode        = 8'd0;
      last_mode   = 8'd0;
      level       = LevelReset;
      cyc_pos     = 3'd0;
      blink_seg   = BlinkSeg0;
      blink_cnt   = BlinkCountRst;
      blink_flag  = BlinkFlagRst;
      fade_seg    = FadeGreenUp;
      rgb[0]      = FadeMax;
      rgb[1]      = 8'd0;
      rgb[2]      = 8'd0;
      chase_pos   = 4'd0;
      mismatches  = 0;
      frames_seen = 0;
    endfunction

    function les_frame_t pattern_frame(logic [4:0] code, logic [2:0] bright);
      les_frame_t f;
      f            = '0;
      f.kind       = KindPattern;
      f.pattern    = code;
      f.brightness = bright;
      return f;
    endfunction

    // Fade channel steps; saturation ends the segment
    function void fade_raise(int ch, logic [2:0] next_seg);
      logic [8:0] sum;
      sum = rgb[ch] + FadeStep;
      if (sum <= FadeMax) begin
        rgb[ch] = sum[7:0];
      end else begin
        rgb[ch]  = FadeMax;
        fade_seg = next_seg;
      end
    endfunction

    function void fade_lower(int ch, logic [2:0] next_seg);
      if (rgb[ch] >= FadeStep) begin
        rgb[ch] = rgb[ch] - FadeStep;
      end else begin
        rgb[ch]  = 8'd0;
        fade_seg = next_seg;
      end
    endfunction

    // Blink sequencer: three segments of flashes followed by silent ticks
    function bit blink_advance(output les_frame_t f);
      logic [4:0] idle_end;
      bit hit;
      hit = 1'b0;
      f   = '0;
      case (blink_seg)
        BlinkSeg0, BlinkSeg2: begin
          idle_end = (blink_seg == BlinkSeg0) ? BlinkIdle0 : BlinkIdle2;
          if (blink_cnt <= BlinkOnLast0) begin
            f   = pattern_frame((blink_flag == BlinkFlagRst) ? PatRed : PatOff, BlinkLevel);
            hit = 1'b1;
            blink_flag = (blink_flag == BlinkFlagRst) ? BlinkFlagOff : blink_flag + 3'd1;
            blink_cnt  = blink_cnt + 5'd1;
          end else if (blink_cnt <= idle_end) begin
            blink_cnt = blink_cnt + 5'd1;
          end else begin
            blink_cnt  = BlinkCountRst;
            blink_seg  = (blink_seg == BlinkSeg0) ? BlinkSeg1 : BlinkSeg0;
            blink_flag = BlinkFlagRst;
          end
        end
        BlinkSeg1: begin
          if (blink_cnt <= BlinkOnLast1) begin
            f   = pattern_frame((blink_flag <= BlinkFlagOnHi) ? PatRed : PatOff, BlinkLevel);
            hit = 1'b1;
            blink_flag = (blink_flag == BlinkFlagLast) ? BlinkFlagRst : blink_flag + 3'd1;
            blink_cnt  = blink_cnt + 5'd1;
          end else if (blink_cnt <= BlinkIdle1) begin
            blink_cnt = blink_cnt + 5'd1;
          end else begin
            blink_cnt  = BlinkCountRst;
            blink_seg  = BlinkSeg2;
            blink_flag = BlinkFlagRst;
          end
        end
        default: ;
      endcase
      return hit;
    endfunction

    // One transaction in, at most one frame out
    function bit advance_effects(les_op_e op, logic [7:0] code, output les_frame_t f);
      logic [7:0] m;
      logic [2:0] p;
      bit hit;
      m   = code;
      hit = 1'b0;
      f   = '0;
      if (op == OpCommand) begin
        case (code)
          ModeCycle: cyc_pos = 3'd0;
          ModeBlink: begin
            blink_seg  = BlinkSeg0;
            blink_cnt  = BlinkCountRst;
            blink_flag = BlinkFlagRst;
          end
          ModeFade:  fade_seg = FadeGreenUp;
          ModeChase: chase_pos = 4'd0;
          ModeBrighter: begin
            if (level < LevelMax) level = level + 3'd1;
            m = last_mode;
          end
          ModeDimmer: begin
            if (level > LevelMin) level = level - 3'd1;
            m = last_mode;
          end
          default: ;
        endcase
        mode      = m;
        last_mode = m;
        if (m <= ModeStaticLoLast || (m >= ModeStaticHiFirst && m <= ModeStaticHiLast)) begin
          f   = pattern_frame(m[4:0], level);
          hit = 1'b1;
        end
      end else begin
        case (mode)
          ModeCycle: begin
            p       = (cyc_pos == CycleBad) ? 3'd0 : cyc_pos;
            f       = pattern_frame(cycle_codes[p], level);
            hit     = 1'b1;
            cyc_pos = (p >= CycleLast) ? 3'd0 : p + 3'd1;
          end
          ModeBlink: hit = blink_advance(f);
          ModeFade: begin
            f.kind       = KindRgb;
            f.pattern    = PatOff;
            f.brightness = level;
            f.red        = rgb[0];
            f.green      = rgb[1];
            f.blue       = rgb[2];
            hit          = 1'b1;
            case (fade_seg)
              FadeGreenUp:  fade_raise(1, FadeRedDown);
              FadeRedDown:  fade_lower(0, FadeBlueUp);
              FadeBlueUp:   fade_raise(2, FadeGreenDn);
              FadeGreenDn:  fade_lower(1, FadeRedUp);
              FadeRedUp:    fade_raise(0, FadeBlueDown);
              FadeBlueDown: fade_lower(2, FadeGreenUp);
              default: ;
            endcase
          end
          ModeChase: begin
            if (chase_pos <= ChaseLast) begin
              f   = pattern_frame(ChaseBase + chase_pos, level);
              hit = 1'b1;
            end
            chase_pos = (chase_pos == ChaseLast) ? ChaseLoop : chase_pos + 4'd1;
          end
          default: ;
        endcase
      end
      return hit;
    endfunction

    function void take_transaction(les_op_e op, logic [7:0] code);
      les_frame_t f;
      if (advance_effects(op, code, f)) due_frames.push_back(f);
    endfunction

    task flag_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        flag_mismatch($sformatf("frame %0d %s: got %0d, expected %0d",
                                frames_seen, name, got, want));
    endtask

    task match_frame(les_frame_t got);
      les_frame_t want;
      frames_seen++;
      if (due_frames.size() == 0) begin
        flag_mismatch($sformatf("frame %0d arrived with none expected", frames_seen));
      end else begin
        want = due_frames.pop_front();
        compare_field("kind", 8'(got.kind), 8'(want.kind));
        compare_field("pattern", 8'(got.pattern), 8'(want.pattern));
        compare_field("brightness", 8'(got.brightness), 8'(want.brightness));
        compare_field("red", got.red, want.red);
        compare_field("green", got.green, want.green);
        compare_field("blue", got.blue, want.blue);
      end
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready_o;
  logic       operation = 1'b0;
  logic [7:0] mode_code = 8'd0;
  logic       out_valid_o;
  logic       out_ready = 1'b0;
  logic       output_kind_o;
  logic [4:0] pattern_code_o;
  logic [2:0] brightness_o;
  logic [7:0] red_o;
  logic [7:0] green_o;
  logic [7:0] blue_o;

  logic          hold_off = 1'b0;
  bit            calm = 1'b0;
  int unsigned   items_sent = 0;
  effect_tracker tracker;

  led_effect_sequencer_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation),
    .mode_code_i    (mode_code),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .output_kind_o  (output_kind_o),
    .pattern_code_o (pattern_code_o),
    .brightness_o   (brightness_o),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Observe both channels on the edge where a transaction completes
  always @(posedge clk_i) begin
    if (rst_ni && tracker != null) begin
      if (in_valid && in_ready_o) tracker.take_transaction(les_op_e'(operation), mode_code);
      if (out_valid_o && out_ready)
        tracker.match_frame(les_frame_t'({output_kind_o, pattern_code_o, brightness_o,
                                          red_o, green_o, blue_o}));
    end
  end

  // Frame sink with random stall bursts
  initial begin : frame_sink
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      out_ready <= !hold_off;
    end
  end

  // Long sink hold-off so the core backs up and drops in_ready
  initial begin : backpressure
    while (items_sent < 500) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Watchdog
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Offer one transaction, with an optional gap first, and hold it until taken
  task automatic send_item(input les_op_e op, input logic [7:0] code);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    operation <= op;
    mode_code <= code;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_ticks(input int unsigned count);
    repeat (count) send_item(OpTick, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] level_step();
    return ($urandom_range(0, 1) != 0) ? ModeBrighter : ModeDimmer;
  endfunction

  initial begin : stimulus
    int unsigned useful;
    int unsigned span;
    int unsigned pick;
    logic [7:0]  code;
    les_op_e     op;

    tracker = new();
    useful  = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: tick after reset, static extremes, level saturation,
    // unknown modes, each animation, level step while animating
    send_ticks(1);
    send_item(OpCommand, 8'd0);
    send_item(OpCommand, ModeStaticLoLast);
    send_item(OpCommand, ModeStaticHiFirst);
    send_item(OpCommand, ModeStaticHiLast);
    send_item(OpCommand, ModeDimmer);
    send_item(OpCommand, ModeDimmer);
    repeat (4) send_item(OpCommand, ModeBrighter);
    send_item(OpCommand, 8'd32);
    send_ticks(1);
    send_item(OpCommand, 8'd255);
    send_item(OpCommand, ModeCycle);
    send_ticks(2);
    send_item(OpCommand, ModeBlink);
    send_ticks(1);
    send_item(OpCommand, ModeFade);
    send_ticks(1);
    send_item(OpCommand, ModeChase);
    send_ticks(1);
    send_item(OpCommand, ModeDimmer);
    send_ticks(1);

    // Random: mostly animation runs, then static modes, noise and unknown modes
    while (useful < 2000) begin
      calm = (useful >= 1700);
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        send_item(OpCommand, ModeCycle + 8'($urandom_range(0, 3)));
        useful++;
        span = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 40);
        repeat (span) begin
          if ($urandom_range(0, 11) == 0) send_item(OpCommand, level_step());
          else send_ticks(1);
          useful++;
        end
      end else if (pick <= 7) begin
        code = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 10))
                                           : 8'($urandom_range(17, 31));
        send_item(OpCommand, code);
        useful++;
        repeat ($urandom_range(0, 3)) begin
          if ($urandom_range(0, 1) != 0) begin
            send_item(OpCommand, level_step());
            useful++;
          end else begin
            send_ticks(1);
          end
        end
      end else if (pick == 8) begin
        repeat ($urandom_range(1, 6)) begin
          op = les_op_e'($urandom_range(0, 1));
          send_item(op, 8'($urandom_range(0, 255)));
          if (op == OpCommand) useful++;
        end
      end else begin
        send_item(OpCommand, 8'($urandom_range(32, 255)));
        useful++;
        send_ticks($urandom_range(0, 3));
      end
    end
    in_valid <= 1'b0;

    // Drain outstanding frames, then wait for strays
    while (tracker.due_frames.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/les_pkg.sv
rtl/core/les_step.sv
rtl/core/led_effect_sequencer_core.sv
tb/led_effect_sequencer_core_test.sv
